FILE: rtl/rotate_about_arbitrary_axis_defines.svh
// ----------------------------------------------------------------------------
// Rotation about an arbitrary axis: assertion macros
// Shared assertion wrappers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ROTATE_ABOUT_ARBITRARY_AXIS_DEFINES_SVH
`define ROTATE_ABOUT_ARBITRARY_AXIS_DEFINES_SVH
`ifndef SYNTH
// Checked while the block is out of reset.
`define RAA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("rotate_about_arbitrary_axis: assertion failed");
// Checked at every edge, reset included.
`define RAA_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("rotate_about_arbitrary_axis: assertion failed");
`else
`define RAA_ASSERT(lbl, clk, rst_n, prop)
`define RAA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/rotaa_pkg.sv
// ----------------------------------------------------------------------------
// Rotation about an arbitrary axis: package
// Shared constants, the normaliser status type and fixed-point helpers.
// ----------------------------------------------------------------------------
package rotaa_pkg;

	// One in Q30 and the rounding term of a Q30 product.
	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam logic [63:0] RND30   = 64'h2000_0000;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	// Taylor series: six nested terms for sine and for cosine.
	localparam int NIT = 6;

	// Exact division by a small constant k for 32-bit values:
	// q = (p * ceil(2^(32+l) / k)) >> (32+l), where 2^(l-1) < k <= 2^l.
	localparam logic [32:0] SIN_M [NIT] = '{
		33'((((64'd1 << 40) + 64'd155) / 64'd156)),
		33'((((64'd1 << 39) + 64'd109) / 64'd110)),
		33'((((64'd1 << 39) + 64'd71) / 64'd72)),
		33'((((64'd1 << 38) + 64'd41) / 64'd42)),
		33'((((64'd1 << 37) + 64'd19) / 64'd20)),
		33'((((64'd1 << 35) + 64'd5) / 64'd6))
	};
	localparam int SIN_SH [NIT] = '{40, 39, 39, 38, 37, 35};

	localparam logic [32:0] COS_M [NIT] = '{
		33'((((64'd1 << 40) + 64'd181) / 64'd182)),
		33'((((64'd1 << 40) + 64'd131) / 64'd132)),
		33'((((64'd1 << 39) + 64'd89) / 64'd90)),
		33'((((64'd1 << 38) + 64'd55) / 64'd56)),
		33'((((64'd1 << 37) + 64'd29) / 64'd30)),
		33'((((64'd1 << 36) + 64'd11) / 64'd12))
	};
	localparam int COS_SH [NIT] = '{40, 40, 39, 38, 37, 36};

	// Axis length and per-component status from the normaliser.
	typedef struct packed {
		logic [2:0][31:0] mag;
		logic [2:0]       neg;
		logic [2:0]       tiny;
		logic [31:0]      len;
		logic             keep;
	} nrm_t;

	// Rounded Q30 product of two non-negative values.
	function automatic logic [31:0] umul30(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = (64'(a) * 64'(b)) + RND30;
		return p[61:30];
	endfunction

	// Signed Q30 product, rounded half away from zero on the magnitude.
	// Operand magnitudes stay within 32 bits everywhere this is used.
	function automatic logic signed [35:0] smul30(input logic signed [35:0] a,
		input logic signed [35:0] b);
		logic [35:0] ma;
		logic [35:0] mb;
		logic [63:0] p;
		logic [35:0] m;
		ma = a[35] ? 36'(-a) : 36'(a);
		mb = b[35] ? 36'(-b) : 36'(b);
		p  = (64'(ma[31:0]) * 64'(mb[31:0])) + RND30;
		m  = {2'b00, p[63:30]};
		return (a[35] != b[35]) ? $signed(36'(-m)) : $signed(m);
	endfunction

endpackage

FILE: rtl/rotaa_if.sv
// ----------------------------------------------------------------------------
// Rotation about an arbitrary axis: channel interfaces
// Item, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface rotaa_item_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [31:0] axis_x;
	logic signed [31:0] axis_y;
	logic signed [31:0] axis_z;
	logic        [15:0] angle;

	modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
		input ready);
	modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
		output ready);
endinterface

interface rotaa_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;

	modport source (output valid, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

interface rotaa_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/rotate_about_arbitrary_axis.sv
// ----------------------------------------------------------------------------
// Rotation about an arbitrary axis: top level
// Rotates a Q16.16 vector about a normalised axis by a binary angle.
// ----------------------------------------------------------------------------
// Usage: each transfer on the item channel carries a vector, an axis of any
// length and a binary angle; each transfer on the result channel returns the
// rotated vector, one result per item and in the same order.
// The cfg channel writes the epsilon threshold at any time it is offered, and
// is always ready; write it only while no items are in flight.
// Throughput is one item per cycle while the receiver does not stall. From the
// item transfer to the result becoming valid there are 16 stages of sine and
// cosine, 2 of squares and sum, 32 of square root (one root bit per stage), 1
// of axis classification, 31 of division (one quotient bit per stage), 1 of
// axis selection and 5 of matrix build and multiply-accumulate.
// Reset clears every stage valid bit and sets epsilon to 7; the pipeline is
// empty afterwards and accepts an item in the first cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and item ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "rotate_about_arbitrary_axis_defines.svh"

module rotate_about_arbitrary_axis import rotaa_pkg::*; #(
	parameter int FRAC_BITS  = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	rotaa_item_if.sink      item,
	rotaa_result_if.source  result,
	rotaa_cfg_if.sink       cfg
);

	localparam int SC_SIDE_W = 192;
	localparam int NM_SIDE_W = 160;

	logic                  en;
	logic [15:0]           epsilon_q;
	logic [SC_SIDE_W-1:0]  sc_side_in;
	logic [SC_SIDE_W-1:0]  sc_side;
	logic                  vld_sc;
	logic signed [31:0]    sn;
	logic signed [31:0]    cs;
	logic signed [31:0]    axis [3];
	logic [NM_SIDE_W-1:0]  nm_side_in;
	logic [NM_SIDE_W-1:0]  nm_side;
	logic                  vld_nm;
	nrm_t                  nrm;
	logic [NM_SIDE_W-1:0]  dv_side;
	logic                  vld_dv;
	logic signed [31:0]    u [3];
	logic signed [31:0]    vec [3];
	logic                  vld_mx;
	logic signed [31:0]    rot [3];

	// The pipeline moves whenever the output register is empty or being taken.
	assign en          = !vld_mx || result.ready;
	assign item.ready  = en;
	assign cfg.ready   = 1'b1;

	// Epsilon register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= 16'd7;
		end else if (cfg.valid && cfg.ready) begin
			epsilon_q <= cfg.data;
		end
	end

	// Sine and cosine first, with vector and axis riding alongside.
	assign sc_side_in = {item.vec_x, item.vec_y, item.vec_z,
		item.axis_x, item.axis_y, item.axis_z};

	rotaa_sincos #(
		.ANGLE_BITS (ANGLE_BITS),
		.SIDE_W     (SC_SIDE_W)
	) u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (item.valid),
		.angle_i (item.angle),
		.side_i  (sc_side_in),
		.vld_o   (vld_sc),
		.sn_o    (sn),
		.cs_o    (cs),
		.side_o  (sc_side)
	);

	// Axis length.
	assign axis[0]    = $signed(sc_side[95:64]);
	assign axis[1]    = $signed(sc_side[63:32]);
	assign axis[2]    = $signed(sc_side[31:0]);
	assign nm_side_in = {sc_side[191:96], sn, cs};

	rotaa_norm #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (NM_SIDE_W)
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_i     (vld_sc),
		.axis_i    (axis),
		.epsilon_i (epsilon_q),
		.side_i    (nm_side_in),
		.vld_o     (vld_nm),
		.nrm_o     (nrm),
		.side_o    (nm_side)
	);

	// Unit axis.
	rotaa_div #(
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (NM_SIDE_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_nm),
		.nrm_i  (nrm),
		.side_i (nm_side),
		.vld_o  (vld_dv),
		.u_o    (u),
		.side_o (dv_side)
	);

	// Matrix and output register.
	assign vec[0] = $signed(dv_side[159:128]);
	assign vec[1] = $signed(dv_side[127:96]);
	assign vec[2] = $signed(dv_side[95:64]);

	rotaa_matrix u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_dv),
		.u_i    (u),
		.sn_i   ($signed(dv_side[63:32])),
		.cs_i   ($signed(dv_side[31:0])),
		.v_i    (vec),
		.vld_o  (vld_mx),
		.out_o  (rot)
	);

	assign result.valid = vld_mx;
	assign result.out_x = rot[0];
	assign result.out_y = rot[1];
	assign result.out_z = rot[2];

	// No result is offered while reset is applied.
	`RAA_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !result.valid)
	// A stall freezes every stage valid bit along the chain.
	`RAA_ASSERT(a_stall_holds, clk, arst_n, !en |=> $stable({vld_sc, vld_nm, vld_dv, vld_mx}))
	// Epsilon changes only through a configuration transfer.
	`RAA_ASSERT(a_eps_stable, clk, arst_n, !(cfg.valid && cfg.ready) |=> $stable(epsilon_q))

endmodule

FILE: rtl/rotaa_sincos.sv
// ----------------------------------------------------------------------------
// Rotation about an arbitrary axis: sine and cosine pipeline
// Binary angle to Q30 radians, nested Taylor series, quadrant mapping.
// ----------------------------------------------------------------------------
module rotaa_sincos import rotaa_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int SIDE_W     = 192
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_i,
	input  logic        [15:0] angle_i,
	input  logic  [SIDE_W-1:0] side_i,
	output logic               vld_o,
	output logic signed [31:0] sn_o,
	output logic signed [31:0] cs_o,
	output logic  [SIDE_W-1:0] side_o
);

	typedef struct packed {
		logic [30:0] x;
		logic [31:0] x2;
		logic [1:0]  quad;
		logic [31:0] ps;
		logic [31:0] pc;
		logic [30:0] ts;
		logic [30:0] tc;
	} sc_t;

	logic [31:0] turn;
	logic [31:0] x_full;
	logic        vld_s1;
	logic [30:0] x_s1;
	logic [1:0]  quad_s1;
	logic [SIDE_W-1:0] side_s1;
	logic        vld_s2;
	logic [30:0] x_s2;
	logic [31:0] x2_s2;
	logic [1:0]  quad_s2;
	logic [SIDE_W-1:0] side_s2;

	sc_t              it_pre [NIT];
	sc_t              it_a_s [NIT];
	sc_t              it_b_s [NIT];
	logic [NIT-1:0]   vld_pre;
	logic [NIT-1:0]   vld_a_s;
	logic [NIT-1:0]   vld_b_s;
	logic [SIDE_W-1:0] side_pre [NIT];
	logic [SIDE_W-1:0] side_a_s [NIT];
	logic [SIDE_W-1:0] side_b_s [NIT];

	logic [31:0] s0_w;
	logic [31:0] cp_w;
	logic        vld_f1;
	logic [30:0] s0_f1;
	logic [31:0] cp_f1;
	logic [1:0]  quad_f1;
	logic [SIDE_W-1:0] side_f1;
	logic signed [33:0] c_raw;
	logic [30:0] c0;
	logic signed [31:0] sp;
	logic signed [31:0] cp;
	logic signed [31:0] sn_w;
	logic signed [31:0] cs_w;
	logic        vld_f2;
	logic signed [31:0] sn_f2;
	logic signed [31:0] cs_f2;
	logic [SIDE_W-1:0] side_f2;

	// Widen the angle to a 32-bit turn and scale the quadrant offset to radians.
	assign turn = 32'(({48'b0, angle_i} & ((64'd1 << ANGLE_BITS) - 64'd1))
		<< (32 - ANGLE_BITS));
	assign x_full = umul30({2'b00, turn[29:0]}, HALF_PI_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_full[30:0];
			quad_s1 <= turn[31:30];
			side_s1 <= side_i;
			x_s2    <= x_s1;
			x2_s2   <= umul30({1'b0, x_s1}, {1'b0, x_s1});
			quad_s2 <= quad_s1;
			side_s2 <= side_s1;
		end
	end

	// Each series term takes two stages: the Q30 product, then the constant divide.
	for (genvar i = 0; i < NIT; i++) begin : g_term
		logic [64:0] qs_prod;
		logic [64:0] qc_prod;
		logic [31:0] qs;
		logic [31:0] qc;
		sc_t         a_nxt;
		sc_t         b_nxt;

		if (i == 0) begin : g_first
			assign it_pre[i] = '{x: x_s2, x2: x2_s2, quad: quad_s2, ps: '0, pc: '0,
				ts: Q30_ONE[30:0], tc: Q30_ONE[30:0]};
			assign vld_pre[i]  = vld_s2;
			assign side_pre[i] = side_s2;
		end else begin : g_next
			assign it_pre[i]   = it_b_s[i-1];
			assign vld_pre[i]  = vld_b_s[i-1];
			assign side_pre[i] = side_b_s[i-1];
		end

		assign qs_prod = 65'(it_a_s[i].ps) * 65'(SIN_M[i]);
		assign qc_prod = 65'(it_a_s[i].pc) * 65'(COS_M[i]);
		assign qs = 32'(qs_prod >> SIN_SH[i]);
		assign qc = 32'(qc_prod >> COS_SH[i]);

		// Next contents of both stages of this term.
		always_comb begin
			a_nxt    = it_pre[i];
			a_nxt.ps = umul30(it_pre[i].x2, {1'b0, it_pre[i].ts});
			a_nxt.pc = umul30(it_pre[i].x2, {1'b0, it_pre[i].tc});
			b_nxt    = it_a_s[i];
			b_nxt.ts = 31'(Q30_ONE - qs);
			b_nxt.tc = 31'(Q30_ONE - qc);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a_s[i] <= 1'b0;
				vld_b_s[i] <= 1'b0;
			end else if (en) begin
				vld_a_s[i] <= vld_pre[i];
				vld_b_s[i] <= vld_a_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_a_s[i]   <= a_nxt;
				side_a_s[i] <= side_pre[i];
				it_b_s[i]   <= b_nxt;
				side_b_s[i] <= side_a_s[i];
			end
		end
	end

	// Final products of the series.
	assign s0_w = umul30({1'b0, it_b_s[NIT-1].x}, {1'b0, it_b_s[NIT-1].ts});
	assign cp_w = umul30(it_b_s[NIT-1].x2, {1'b0, it_b_s[NIT-1].tc});

	// Cosine is clamped to [0, 1]; the quadrant sets signs and a sine/cosine swap.
	assign c_raw = $signed({2'b00, Q30_ONE}) - $signed({3'b000, cp_f1[31:1]});
	always_comb begin
		if (c_raw < 0) begin
			c0 = '0;
		end else if (c_raw > $signed({2'b00, Q30_ONE})) begin
			c0 = Q30_ONE[30:0];
		end else begin
			c0 = c_raw[30:0];
		end
	end
	assign sp = $signed({1'b0, s0_f1});
	assign cp = $signed({1'b0, c0});

	always_comb begin
		case (quad_f1)
			2'd0: begin
				sn_w = sp;
				cs_w = cp;
			end
			2'd1: begin
				sn_w = cp;
				cs_w = -sp;
			end
			2'd2: begin
				sn_w = -sp;
				cs_w = -cp;
			end
			default: begin
				sn_w = -cp;
				cs_w = sp;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1 <= 1'b0;
			vld_f2 <= 1'b0;
		end else if (en) begin
			vld_f1 <= vld_b_s[NIT-1];
			vld_f2 <= vld_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s0_f1   <= s0_w[30:0];
			cp_f1   <= cp_w;
			quad_f1 <= it_b_s[NIT-1].quad;
			side_f1 <= side_b_s[NIT-1];
			sn_f2   <= sn_w;
			cs_f2   <= cs_w;
			side_f2 <= side_f1;
		end
	end

	assign vld_o  = vld_f2;
	assign sn_o   = sn_f2;
	assign cs_o   = cs_f2;
	assign side_o = side_f2;

endmodule

FILE: rtl/rotaa_norm.sv
// ----------------------------------------------------------------------------
// Rotation about an arbitrary axis: axis length pipeline
// Squares, sum and a bit-per-stage square root of the axis length.
// ----------------------------------------------------------------------------
module rotaa_norm import rotaa_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 160
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_i,
	input  logic signed [31:0] axis_i [3],
	input  logic        [15:0] epsilon_i,
	input  logic  [SIDE_W-1:0] side_i,
	output logic               vld_o,
	output nrm_t               nrm_o,
	output logic  [SIDE_W-1:0] side_o
);

	localparam int NSQ = 32;
	localparam logic [31:0] LEN_ONE = 32'(64'd1 << FRAC_BITS);

	logic [2:0][31:0] mag_w;
	logic             vld_s1;
	logic [63:0]      sq_s1 [3];
	logic [2:0][31:0] mag_s1;
	logic [2:0]       neg_s1;
	logic [SIDE_W-1:0] side_s1;
	logic             vld_s2;
	logic [63:0]      sum_s2;
	logic [2:0][31:0] mag_s2;
	logic [2:0]       neg_s2;
	logic [SIDE_W-1:0] side_s2;

	logic [34:0]      rem_pre [NSQ];
	logic [63:0]      rad_pre [NSQ];
	logic [31:0]      root_pre [NSQ];
	logic [NSQ-1:0]   vld_pre;
	logic [34:0]      rem_s [NSQ];
	logic [63:0]      rad_s [NSQ];
	logic [31:0]      root_s [NSQ];
	logic [NSQ-1:0]   vld_sq_s;
	logic [2:0][31:0] mag_pre [NSQ];
	logic [2:0][31:0] mag_sq_s [NSQ];
	logic [2:0]       neg_pre [NSQ];
	logic [2:0]       neg_sq_s [NSQ];
	logic [SIDE_W-1:0] side_pre [NSQ];
	logic [SIDE_W-1:0] side_sq_s [NSQ];

	nrm_t             nrm_w;
	logic             vld_s3;
	nrm_t             nrm_s3;
	logic [SIDE_W-1:0] side_s3;

	// Component magnitudes; the most negative value maps to 2^31.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag_w[k] = axis_i[k][31] ? 32'(-axis_i[k]) : 32'(axis_i[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	// Squares in the first stage, their sum in the second.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s1[k]  <= 64'(mag_w[k]) * 64'(mag_w[k]);
				neg_s1[k] <= axis_i[k][31];
			end
			mag_s1  <= mag_w;
			side_s1 <= side_i;
			sum_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
		end
	end

	// One root bit per stage, two radicand bits shifted in each time.
	for (genvar i = 0; i < NSQ; i++) begin : g_root
		logic [34:0] rem_sh;
		logic [33:0] trial;
		logic        ge;

		if (i == 0) begin : g_first
			assign rem_pre[i]  = '0;
			assign rad_pre[i]  = sum_s2;
			assign root_pre[i] = '0;
			assign vld_pre[i]  = vld_s2;
			assign mag_pre[i]  = mag_s2;
			assign neg_pre[i]  = neg_s2;
			assign side_pre[i] = side_s2;
		end else begin : g_next
			assign rem_pre[i]  = rem_s[i-1];
			assign rad_pre[i]  = rad_s[i-1];
			assign root_pre[i] = root_s[i-1];
			assign vld_pre[i]  = vld_sq_s[i-1];
			assign mag_pre[i]  = mag_sq_s[i-1];
			assign neg_pre[i]  = neg_sq_s[i-1];
			assign side_pre[i] = side_sq_s[i-1];
		end

		assign rem_sh = {rem_pre[i][32:0], rad_pre[i][63:62]};
		assign trial  = {root_pre[i], 2'b01};
		assign ge     = rem_sh >= {1'b0, trial};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq_s[i] <= 1'b0;
			end else if (en) begin
				vld_sq_s[i] <= vld_pre[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]     <= ge ? (rem_sh - {1'b0, trial}) : rem_sh;
				root_s[i]    <= {root_pre[i][30:0], ge};
				rad_s[i]     <= {rad_pre[i][61:0], 2'b00};
				mag_sq_s[i]  <= mag_pre[i];
				neg_sq_s[i]  <= neg_pre[i];
				side_sq_s[i] <= side_pre[i];
			end
		end
	end

	// A length of exactly zero or one keeps the axis; small parts are flagged.
	always_comb begin
		nrm_w.mag  = mag_sq_s[NSQ-1];
		nrm_w.neg  = neg_sq_s[NSQ-1];
		nrm_w.len  = root_s[NSQ-1];
		nrm_w.keep = (root_s[NSQ-1] == '0) || (root_s[NSQ-1] == LEN_ONE);
		for (int k = 0; k < 3; k++) begin
			nrm_w.tiny[k] = mag_sq_s[NSQ-1][k] < {16'b0, epsilon_i};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_sq_s[NSQ-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s3  <= nrm_w;
			side_s3 <= side_sq_s[NSQ-1];
		end
	end

	assign vld_o  = vld_s3;
	assign nrm_o  = nrm_s3;
	assign side_o = side_s3;

endmodule

FILE: rtl/rotaa_div.sv
// ----------------------------------------------------------------------------
// Rotation about an arbitrary axis: unit axis pipeline
// Three restoring dividers, one quotient bit per stage, then selection.
// ----------------------------------------------------------------------------
module rotaa_div import rotaa_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 160
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_i,
	input  nrm_t               nrm_i,
	input  logic  [SIDE_W-1:0] side_i,
	output logic               vld_o,
	output logic signed [31:0] u_o [3],
	output logic  [SIDE_W-1:0] side_o
);

	// Quotients of a component by the length never exceed one in Q30.
	localparam int NDV = 31;

	logic [31:0]      rem_pre [NDV][3];
	logic [30:0]      quo_pre [NDV][3];
	logic [31:0]      rem_s [NDV][3];
	logic [30:0]      quo_s [NDV][3];
	nrm_t             nrm_pre [NDV];
	nrm_t             nrm_dv_s [NDV];
	logic [NDV-1:0]   vld_pre;
	logic [NDV-1:0]   vld_dv_s;
	logic [SIDE_W-1:0] side_pre [NDV];
	logic [SIDE_W-1:0] side_dv_s [NDV];

	nrm_t             nrm_f;
	logic [31:0]      um [3];
	logic signed [31:0] u_w [3];
	logic             vld_fin;
	logic signed [31:0] u_fin [3];
	logic [SIDE_W-1:0] side_fin;

	for (genvar i = 0; i < NDV; i++) begin : g_step
		logic [2:0] bin;

		// The numerator is the magnitude shifted up by 30; its top bits seed the remainder.
		if (i == 0) begin : g_first
			for (genvar k = 0; k < 3; k++) begin : g_lane
				assign rem_pre[i][k] = {1'b0, nrm_i.mag[k][31:1]};
				assign quo_pre[i][k] = '0;
				assign bin[k]        = nrm_i.mag[k][0];
			end
			assign nrm_pre[i]  = nrm_i;
			assign vld_pre[i]  = vld_i;
			assign side_pre[i] = side_i;
		end else begin : g_next
			for (genvar k = 0; k < 3; k++) begin : g_lane
				assign rem_pre[i][k] = rem_s[i-1][k];
				assign quo_pre[i][k] = quo_s[i-1][k];
				assign bin[k]        = 1'b0;
			end
			assign nrm_pre[i]  = nrm_dv_s[i-1];
			assign vld_pre[i]  = vld_dv_s[i-1];
			assign side_pre[i] = side_dv_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv_s[i] <= 1'b0;
			end else if (en) begin
				vld_dv_s[i] <= vld_pre[i];
			end
		end

		// Compare and subtract for each lane.
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					if ({rem_pre[i][k], bin[k]} >= {1'b0, nrm_pre[i].len}) begin
						rem_s[i][k] <= 32'({rem_pre[i][k], bin[k]} - {1'b0, nrm_pre[i].len});
						quo_s[i][k] <= {quo_pre[i][k][29:0], 1'b1};
					end else begin
						rem_s[i][k] <= {rem_pre[i][k][30:0], bin[k]};
						quo_s[i][k] <= {quo_pre[i][k][29:0], 1'b0};
					end
				end
				nrm_dv_s[i]  <= nrm_pre[i];
				side_dv_s[i] <= side_pre[i];
			end
		end
	end

	// Kept axes are only rescaled; small components drop to zero.
	assign nrm_f = nrm_dv_s[NDV-1];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (nrm_f.keep) begin
				um[k] = 32'({32'b0, nrm_f.mag[k]} << (30 - FRAC_BITS));
			end else if (nrm_f.tiny[k]) begin
				um[k] = '0;
			end else begin
				um[k] = {1'b0, quo_s[NDV-1][k]};
			end
			u_w[k] = nrm_f.neg[k] ? $signed(32'(-um[k])) : $signed(um[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_fin <= 1'b0;
		end else if (en) begin
			vld_fin <= vld_dv_s[NDV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_fin    <= u_w;
			side_fin <= side_dv_s[NDV-1];
		end
	end

	assign vld_o  = vld_fin;
	assign u_o    = u_fin;
	assign side_o = side_fin;

endmodule

FILE: rtl/rotaa_matrix.sv
// ----------------------------------------------------------------------------
// Rotation about an arbitrary axis: rotation matrix pipeline
// Builds the axis-angle matrix and applies it to the vector with saturation.
// ----------------------------------------------------------------------------
module rotaa_matrix import rotaa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_i,
	input  logic signed [31:0] u_i [3],
	input  logic signed [31:0] sn_i,
	input  logic signed [31:0] cs_i,
	input  logic signed [31:0] v_i [3],
	output logic               vld_o,
	output logic signed [31:0] out_o [3]
);

	localparam logic signed [35:0] ONE36 = $signed({4'b0, Q30_ONE});
	localparam logic signed [37:0] SAT_HI = 38'sd2147483647;
	localparam logic signed [37:0] SAT_LO = -38'sd2147483648;

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [35:0] xx_s1, yy_s1, zz_s1, xyp_s1, xzp_s1, yzp_s1;
	logic signed [35:0] su_s1 [3];
	logic signed [35:0] omc_s1, cs_s1;
	logic signed [35:0] v_s1 [3];
	logic signed [35:0] xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2;
	logic signed [35:0] dxx_s2, dyy_s2, dzz_s2;
	logic signed [35:0] su_s2 [3];
	logic signed [35:0] v_s2 [3];
	logic signed [35:0] r_s3 [3][3];
	logic signed [35:0] v_s3 [3];
	logic signed [35:0] tm_s4 [3][3];
	logic signed [37:0] acc [3];
	logic signed [31:0] out_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Outer products of the axis and the sine terms.
	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1  <= smul30(36'(u_i[0]), 36'(u_i[0]));
			yy_s1  <= smul30(36'(u_i[1]), 36'(u_i[1]));
			zz_s1  <= smul30(36'(u_i[2]), 36'(u_i[2]));
			xyp_s1 <= smul30(36'(u_i[0]), 36'(u_i[1]));
			xzp_s1 <= smul30(36'(u_i[0]), 36'(u_i[2]));
			yzp_s1 <= smul30(36'(u_i[1]), 36'(u_i[2]));
			for (int k = 0; k < 3; k++) begin
				su_s1[k] <= smul30(36'(sn_i), 36'(u_i[k]));
				v_s1[k]  <= 36'(v_i[k]);
			end
			omc_s1 <= ONE36 - 36'(cs_i);
			cs_s1  <= 36'(cs_i);
		end
	end

	// Off-diagonal terms take one minus cosine; the diagonal takes cosine.
	always_ff @(posedge clk) begin
		if (en) begin
			xy_s2  <= smul30(xyp_s1, omc_s1);
			xz_s2  <= smul30(xzp_s1, omc_s1);
			yz_s2  <= smul30(yzp_s1, omc_s1);
			dxx_s2 <= smul30(cs_s1, ONE36 - xx_s1);
			dyy_s2 <= smul30(cs_s1, ONE36 - yy_s1);
			dzz_s2 <= smul30(cs_s1, ONE36 - zz_s1);
			xx_s2  <= xx_s1;
			yy_s2  <= yy_s1;
			zz_s2  <= zz_s1;
			su_s2  <= su_s1;
			v_s2   <= v_s1;
		end
	end

	// Matrix entries.
	always_ff @(posedge clk) begin
		if (en) begin
			r_s3[0][0] <= xx_s2 + dxx_s2;
			r_s3[0][1] <= xy_s2 - su_s2[2];
			r_s3[0][2] <= xz_s2 + su_s2[1];
			r_s3[1][0] <= xy_s2 + su_s2[2];
			r_s3[1][1] <= yy_s2 + dyy_s2;
			r_s3[1][2] <= yz_s2 - su_s2[0];
			r_s3[2][0] <= xz_s2 - su_s2[1];
			r_s3[2][1] <= yz_s2 + su_s2[0];
			r_s3[2][2] <= zz_s2 + dzz_s2;
			v_s3       <= v_s2;
		end
	end

	// Each term is rounded back to the vector format on its own.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					tm_s4[i][j] <= smul30(r_s3[i][j], v_s3[j]);
				end
			end
		end
	end

	// Row sums with saturation to 32 bits.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = 38'(tm_s4[i][0]) + 38'(tm_s4[i][1]) + 38'(tm_s4[i][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (acc[i] > SAT_HI) begin
					out_s5[i] <= SAT_HI[31:0];
				end else if (acc[i] < SAT_LO) begin
					out_s5[i] <= SAT_LO[31:0];
				end else begin
					out_s5[i] <= acc[i][31:0];
				end
			end
		end
	end

	assign vld_o = vld_s5;
	assign out_o = out_s5;

endmodule
